/* rtl/fsr_pkg.sv */
// Package for the binary32 square root core: constants, the pipeline item type.
// Used by every module in rtl; depends on nothing.
`default_nettype none
package fsr_pkg;
  localparam logic [31:0] QNAN_BITS  = 32'h7fc0_0000;
  localparam logic [31:0] HALF_BASE  = 32'h3f00_0000;
  localparam int          FRAC_BITS  = 23;
  localparam int          ROOT_BITS  = 25;
  localparam int          STEPS      = 5;
  localparam int          NUM_STAGES = ROOT_BITS / STEPS;
  localparam int          REM_W      = 28;

  typedef struct packed {
    logic                    vld;
    logic                    sp;
    logic [31:0]             sp_res;
    logic                    inv;
    logic signed [8:0]       half;
    logic [ROOT_BITS-1:0]    q;
    logic [REM_W-1:0]        rem;
  } fsr_item_t;
endpackage
`default_nettype wire

/* rtl/fsr_norm.sv */
// Front stage: special-case decode, subnormal normalization, exponent halving.
// Depends on fsr_pkg.
`default_nettype none
module fsr_norm (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               en,
  input  wire               in_vld,
  input  wire [31:0]        operand,
  output fsr_pkg::fsr_item_t item_r
);
  import fsr_pkg::*;

  fsr_item_t         item_nxt;
  logic              zero, neg, infnan;
  logic [4:0]        lz;
  logic [4:0]        shamt;
  logic [23:0]       mant;
  logic signed [9:0] e;
  logic [24:0]       sig;

  always_comb begin
    zero   = (operand[30:0] == 31'd0);
    neg    = operand[31];
    infnan = (operand[30:23] == 8'hff);
    lz     = 5'd0;
    for (int j = 0; j < FRAC_BITS; j++) begin
      if (operand[j]) begin
        lz = 5'(FRAC_BITS - 1 - j);
      end
    end
    shamt = lz + 5'd1;
    if (operand[30:23] == 8'd0) begin
      mant = {1'b0, operand[22:0]} << shamt;
      e    = 10'sd1 - $signed({5'd0, shamt}) - 10'sd127;
    end else begin
      mant = {1'b1, operand[22:0]};
      e    = $signed({2'b00, operand[30:23]}) - 10'sd127;
    end
    sig = e[0] ? {mant, 1'b0} : {1'b0, mant};
    item_nxt.vld    = in_vld;
    item_nxt.sp     = zero || neg || infnan;
    item_nxt.sp_res = (neg && !zero) ? QNAN_BITS : operand;
    item_nxt.inv    = neg && !zero;
    item_nxt.half   = 9'(e >>> 1);
    item_nxt.q      = '0;
    item_nxt.rem    = {2'b00, sig, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (en) begin
      item_r <= item_nxt;
    end
  end
endmodule
`default_nettype wire

/* rtl/fsr_root_stage.sv */
// One pipeline stage of the restoring root recurrence, STEPS result bits.
// Depends on fsr_pkg.
`default_nettype none
module fsr_root_stage #(
  parameter int FIRST_BIT = 24
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     en,
  input  wire fsr_pkg::fsr_item_t item_in,
  output fsr_pkg::fsr_item_t      item_r
);
  import fsr_pkg::*;

  fsr_item_t         item_nxt;
  logic [REM_W-1:0]  tr;
  logic [REM_W-1:0]  bitv;

  always_comb begin
    item_nxt = item_in;
    for (int j = 0; j < STEPS; j++) begin
      bitv = REM_W'(1) << (FIRST_BIT - j);
      tr   = {2'b00, item_nxt.q, 1'b0} + bitv;
      if (tr <= item_nxt.rem) begin
        item_nxt.rem = item_nxt.rem - tr;
        item_nxt.q   = item_nxt.q | bitv[ROOT_BITS-1:0];
      end
      item_nxt.rem = item_nxt.rem << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (en) begin
      item_r <= item_nxt;
    end
  end
endmodule
`default_nettype wire

/* rtl/float32_square_root_core.sv */
// Top level of the pipelined binary32 square root core.
// Depends on fsr_pkg, fsr_norm and fsr_root_stage.
//
// Channel  Direction  Handshake            Payload
// in_      request    in_valid/in_stall    in_operand_bits[31:0]
// out_     result     out_valid/out_stall  out_root_bits, out_invalid_flag, out_inexact_flag
//
// One request is taken per cycle unless a stalled result holds the pipeline.
// The seven registers are one decode stage, five root stages of five steps, one rounding stage.
// Reset clears all stage valid bits; no result is pending after reset.
// A stall while a result is presented freezes the whole pipeline and stalls the input.
`default_nettype none
module float32_square_root_core (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [31:0] in_operand_bits,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [31:0] out_root_bits,
  output logic       out_invalid_flag,
  output logic       out_inexact_flag
);
  import fsr_pkg::*;

  logic        en;
  fsr_item_t   stg [NUM_STAGES+1];
  logic        out_valid_r;
  logic [31:0] root_r, root_nxt;
  logic        inv_r, inx_r, inx_nxt;
  logic [ROOT_BITS-1:0] qr;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  fsr_norm u_norm (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
    .operand(in_operand_bits), .item_r(stg[0])
  );

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_root
    fsr_root_stage #(.FIRST_BIT(ROOT_BITS - 1 - k * STEPS)) u_stage (
      .clk(clk), .rst_n(rst_n), .en(en), .item_in(stg[k]), .item_r(stg[k+1])
    );
  end

  always_comb begin
    qr       = stg[NUM_STAGES].q + {{(ROOT_BITS-1){1'b0}}, stg[NUM_STAGES].q[0]};
    inx_nxt  = !stg[NUM_STAGES].sp && (stg[NUM_STAGES].rem != '0);
    if (stg[NUM_STAGES].sp) begin
      root_nxt = stg[NUM_STAGES].sp_res;
    end else begin
      root_nxt = 32'(inx_nxt ? qr[ROOT_BITS-1:1] : stg[NUM_STAGES].q[ROOT_BITS-1:1])
                 + HALF_BASE
                 + ({{23{stg[NUM_STAGES].half[8]}}, stg[NUM_STAGES].half} << FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stg[NUM_STAGES].vld;
      root_r      <= root_nxt;
      inv_r       <= stg[NUM_STAGES].inv;
      inx_r       <= inx_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_root_bits    = root_r;
  assign out_invalid_flag = inv_r;
  assign out_inexact_flag = inx_r;

  a_nan_on_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid_flag |-> out_root_bits == QNAN_BITS)
    else $error("invalid result is not the quiet NaN");
  a_invalid_exact: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid_flag |-> !out_inexact_flag)
    else $error("invalid and inexact both raised");
  a_inexact_finite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inexact_flag |-> out_root_bits[30:23] != 8'hff && !out_root_bits[31])
    else $error("rounded result is not a positive finite number");
endmodule
`default_nettype wire

/* tb/float32_square_root_checker.sv */
// Checker for the binary32 square root core: watches both channels, predicts each root
// and compares it field by field. Depends on nothing but the port signals of the core.
`timescale 1ns / 100ps
module float32_square_root_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_stall,
  input  wire [31:0] in_operand_bits,
  input  wire        out_valid,
  input  wire        out_stall,
  input  wire [31:0] out_root_bits,
  input  wire        out_invalid_flag,
  input  wire        out_inexact_flag,
  output int         fail_count,
  output int         pending_roots
);
  typedef struct packed {
    logic [31:0] root;
    logic        inv;
    logic        inx;
  } root_t;

  root_t expected_roots[$];

  function automatic root_t compute_root(input logic [31:0] x);
    root_t r;
    int be, i, t, half;
    logic [31:0] sig, q;
    longint rem, s, tr, b;
    r = '0;
    if (x[30:0] == 0) begin
      r.root = x;
    end else if (x[31]) begin
      r.root = 32'h7fc0_0000;
      r.inv = 1'b1;
    end else if (x[30:23] == 8'hff) begin
      r.root = x;
    end else begin
      be = x[30:23];
      sig = x;
      if (be == 0) begin
        i = 0;
        while (!sig[23] && i < 32) begin
          sig = sig << 1;
          i++;
        end
        be = 1 - i;
      end
      sig = {8'h00, 1'b1, sig[22:0]};
      t = be - 127 + 256;
      if (t % 2 != 0) sig = sig << 1;
      half = t / 2 - 128;
      rem = longint'(sig) * 2;
      s = 0;
      q = 0;
      for (b = 64'h100_0000; b != 0; b = b >> 1) begin
        tr = s + b;
        if (tr <= rem) begin
          s = tr + b;
          rem -= tr;
          q += 32'(b);
        end
        rem *= 2;
      end
      if (rem != 0) begin
        r.inx = 1'b1;
        q += {31'b0, q[0]};
      end
      r.root = (q >> 1) + 32'h3f00_0000 + (32'(half) << 23);
    end
    return r;
  endfunction

  assign pending_roots = expected_roots.size();

  always @(posedge clk) begin
    root_t e;
    if (rst_n && in_valid && !in_stall) expected_roots.push_back(compute_root(in_operand_bits));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_roots.size() == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < 10) $display("unexpected result %h", out_root_bits);
      end else begin
        e = expected_roots.pop_front();
        if (e.root !== out_root_bits || e.inv !== out_invalid_flag
            || e.inx !== out_inexact_flag) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("mismatch: expected %h inv %b inx %b, got %h inv %b inx %b",
                     e.root, e.inv, e.inx, out_root_bits, out_invalid_flag, out_inexact_flag);
        end
      end
    end
  end
endmodule

/* tb/float32_square_root_core_tb.sv */
// Testbench top for the binary32 square root core: drives directed and random requests
// under varied idling and stalls and gives the verdict. Depends on the core and its checker.
`timescale 1ns / 100ps
module float32_square_root_core_tb;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [31:0] in_operand_bits = '0;
  logic out_stall = 1'b0;
  wire in_stall, out_valid, out_invalid_flag, out_inexact_flag;
  wire [31:0] out_root_bits;
  int fail_count, pending_roots;
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 1'b0;
  int cycles = 0;

  float32_square_root_core uut (.*);
  float32_square_root_checker chk (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("[float32_square_root_core] ERROR");
      $finish;
    end
  end

  always @(negedge clk)
    out_stall <= hold_off || ($urandom_range(99) < recv_stall);

  function automatic logic [31:0] random_operand();
    case ($urandom_range(5))
      0: return {1'b0, 8'h00, 23'($urandom)};
      1: return {1'b0, 8'($urandom_range(90, 165)), 23'($urandom)};
      2: return {1'($urandom), 8'hff, 23'($urandom)};
      3: return {1'b1, 31'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [31:0] x);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operand_bits <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  logic [31:0] directed_ops[$] = '{
    32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h007f_ffff, 32'h0080_0000,
    32'h3f80_0000, 32'h4000_0000, 32'h4080_0000, 32'h7f7f_ffff, 32'h7f80_0000,
    32'hff80_0000, 32'h7fc0_0000, 32'h7f80_0001, 32'hffc0_0000, 32'hbf80_0000,
    32'h8000_0001, 32'h4040_0000, 32'h3f7f_ffff, 32'hffff_ffff, 32'h0040_0000,
    32'h7fff_ffff, 32'h5555_5555, 32'h2aaa_aaaa};

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed_ops[i]) send_request(directed_ops[i]);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 67 : 17) : 0;
      recv_stall = (ph == 2) ? 67 : (ph == 3 ? 17 : 0);
      for (int n = 0; n < 110; n++) send_request(random_operand());
      in_valid <= 1'b0;
      while (pending_roots != 0) @(negedge clk);
    end
    fork
      begin
        hold_off = 1'b1;
        repeat (40) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 20; n++) send_request(random_operand());
    join
    in_valid <= 1'b0;
    while (pending_roots != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_roots == 0) begin
      $display("[float32_square_root_core] OK");
    end else begin
      $display("[float32_square_root_core] ERROR");
    end
    $finish;
  end
endmodule
